[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the hash program operation executor.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define HPOX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be true outside reset.
`define HPOX_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

[hdl/hpox_pkg.sv]
// Types, codes and helper functions of the hash program operation executor.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package hpox_pkg;

	localparam int KIND_W  = 5;
	localparam int OFS_W   = 5;
	localparam int WORD_W  = 64;
	localparam int LANES   = 8;
	localparam int LANE_W  = 3;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_MOV_IN    = 5'd0;
	localparam logic [KIND_W-1:0] KIND_MOV_IMM   = 5'd1;
	localparam logic [KIND_W-1:0] KIND_ROL       = 5'd2;
	localparam logic [KIND_W-1:0] KIND_ROR       = 5'd3;
	localparam logic [KIND_W-1:0] KIND_MUL       = 5'd4;
	localparam logic [KIND_W-1:0] KIND_AND_IMM   = 5'd5;
	localparam logic [KIND_W-1:0] KIND_SHL       = 5'd6;
	localparam logic [KIND_W-1:0] KIND_SHR       = 5'd7;
	localparam logic [KIND_W-1:0] KIND_OR_IMM    = 5'd8;
	localparam logic [KIND_W-1:0] KIND_XOR_IMM   = 5'd9;
	localparam logic [KIND_W-1:0] KIND_XOR_IN    = 5'd10;
	localparam logic [KIND_W-1:0] KIND_AND_IN    = 5'd11;
	localparam logic [KIND_W-1:0] KIND_ADD_IN    = 5'd12;
	localparam logic [KIND_W-1:0] KIND_SUB_IN    = 5'd13;
	localparam logic [KIND_W-1:0] KIND_MOV_STATE = 5'd14;
	localparam logic [KIND_W-1:0] KIND_XOR_STATE = 5'd15;
	localparam logic [KIND_W-1:0] KIND_SUB_STATE = 5'd16;
	localparam logic [KIND_W-1:0] KIND_ADD_STATE = 5'd17;
	localparam logic [KIND_W-1:0] KIND_NOT       = 5'd18;

	// Width codes.
	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL_X1,
		ST_MUL_X2,
		ST_WB
	} state_t;

	typedef logic [LANES-1:0][7:0] lane_bytes_t;

	function automatic logic [WORD_W-1:0] width_mask(input logic [1:0] wc);
		unique case (wc)
			WC_8:    width_mask = 64'h0000_0000_0000_00ff;
			WC_16:   width_mask = 64'h0000_0000_0000_ffff;
			WC_32:   width_mask = 64'h0000_0000_ffff_ffff;
			default: width_mask = 64'hffff_ffff_ffff_ffff;
		endcase
	endfunction

	function automatic logic [3:0] width_bytes(input logic [1:0] wc);
		width_bytes = 4'd1 << wc;
	endfunction

	// Row of a lane for a word that starts at off; lanes below the start
	// lane hold the tail of the word in the next row.
	function automatic logic [2:0] lane_row(input logic [OFS_W-1:0] off, input int lane);
		lane_row = (LANE_W'(lane) < off[LANE_W-1:0]) ? {1'b0, off[4:3]} + 3'd1
		                                              : {1'b0, off[4:3]};
	endfunction

	// Rotate the lane bytes into word order; bytes never written read as zero.
	function automatic logic [WORD_W-1:0] gather(input lane_bytes_t lanes,
	                                             input logic [LANES-1:0] vld,
	                                             input logic [LANE_W-1:0] start);
		logic [LANE_W-1:0] ln;
		gather = '0;
		for (int i = 0; i < LANES; i++) begin
			ln = start + LANE_W'(i);
			if (vld[ln]) begin
				gather[8*i +: 8] = lanes[ln];
			end
		end
	endfunction

endpackage

[hdl/hpox_op_if.sv]
// Operation channel of the hash program operation executor.
// Depends on hpox_pkg for the field widths.
`timescale 1ns / 1ps

interface hpox_op_if;
	import hpox_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [1:0]          width_code;
	logic [OFS_W-1:0]    dest_offset;
	logic [OFS_W-1:0]    src_offset;
	logic [WORD_W-1:0]   operand;
	logic [WORD_W-1:0]   input_word;

	modport source (
		output valid, kind, width_code, dest_offset, src_offset, operand, input_word,
		input  ready
	);

	modport sink (
		input  valid, kind, width_code, dest_offset, src_offset, operand, input_word,
		output ready
	);
endinterface

[hdl/hpox_res_if.sv]
// Result channel of the hash program operation executor.
// Depends on hpox_pkg for the field widths.
`timescale 1ns / 1ps

interface hpox_res_if;
	import hpox_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] written_value;
	logic              out_of_range;

	modport source (
		output valid, written_value, out_of_range,
		input  ready
	);

	modport sink (
		input  valid, written_value, out_of_range,
		output ready
	);
endinterface

[hdl/hash_program_op_executor_core.sv]
// The operation beat is captured in the s1 registers when it is accepted; the result is
// registered at write back, after ST_MUL_X1 and ST_MUL_X2 for a 64-bit multiply.
// An operation is accepted only in ST_IDLE, after the last one has been read from the
// byte lanes and written back; a 64-bit multiply also runs through the shared 32x32
// multiplier. A result that waits in the output register stalls the next write back.
// Reset clears the per-byte valid flags, so the store reads as zero; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hash_program_op_executor_core #(
	parameter int STORE_BYTES = 32
) (
	input logic        clk,
	input logic        arst_n,
	hpox_op_if.sink    op,
	hpox_res_if.source res
);
	import hpox_pkg::*;

	localparam int ROWS  = (STORE_BYTES + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	function automatic logic [ROW_W-1:0] to_row(input logic [2:0] r);
		to_row = (int'(r) < ROWS) ? ROW_W'(r) : '0;
	endfunction

	state_t state_q, state_d;

	// Byte lanes: lane j holds the bytes whose address is j modulo eight.
	logic [7:0]                       bank_q [LANES][ROWS];
	logic [LANES-1:0][ROWS-1:0]       vld_q;

	logic [LANES-1:0][ROW_W-1:0]      row_a, row_b, row_w;
	logic [LANES-1:0]                 lane_we;
	lane_bytes_t                      lane_wdata;

	lane_bytes_t                      rd_a_s1, rd_b_s1;
	logic [LANES-1:0]                 va_s1, vb_s1;
	logic [KIND_W-1:0]                kind_s1;
	logic [1:0]                       wc_s1;
	logic [OFS_W-1:0]                 dst_s1, src_s1;
	logic [WORD_W-1:0]                imm_s1, inw_s1;
	logic                             oor_s1, legal_s1;

	logic [WORD_W-1:0]                res_q;
	logic                             res_valid_q;
	logic [WORD_W-1:0]                res_value_q;
	logic                             res_oor_q;

	logic                             op_acc;
	logic [6:0]                       dst_end, src_end;
	logic                             uses_src, oor_in;

	logic [WORD_W-1:0]                m_s1, a_w, b_w, r_w, commit_raw, commit_val;
	logic [6:0]                       bits_w;
	logic [5:0]                       rot_s;
	logic                             shift_big, long_mul, out_free;
	logic                             commit_en, commit_write;
	logic [31:0]                      mul_x, mul_y;
	logic [WORD_W-1:0]                mul_p;

	assign op_acc   = op.valid && op.ready;
	assign op.ready = (state_q == ST_IDLE);
	assign out_free = !res_valid_q || res.ready;

	// Range check on the incoming operation.
	assign dst_end  = 7'(op.dest_offset) + 7'(width_bytes(op.width_code));
	assign src_end  = 7'(op.src_offset) + 7'(width_bytes(op.width_code));
	assign uses_src = (op.kind == KIND_MOV_STATE) || (op.kind == KIND_XOR_STATE) ||
	                  (op.kind == KIND_SUB_STATE) || (op.kind == KIND_ADD_STATE);
	assign oor_in   = (int'(dst_end) > STORE_BYTES) ||
	                  (uses_src && (int'(src_end) > STORE_BYTES));

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			row_a[j] = to_row(lane_row(op.dest_offset, j));
			row_b[j] = to_row(lane_row(op.src_offset, j));
			row_w[j] = to_row(lane_row(dst_s1, j));
		end
	end

	always_ff @(posedge clk) begin
		if (op_acc) begin
			kind_s1  <= op.kind;
			wc_s1    <= op.width_code;
			dst_s1   <= op.dest_offset;
			src_s1   <= op.src_offset;
			imm_s1   <= op.operand & width_mask(op.width_code);
			inw_s1   <= op.input_word & width_mask(op.width_code);
			oor_s1   <= oor_in;
			legal_s1 <= (op.kind <= KIND_NOT);
		end
	end

	// Lane memories: reads happen only on an accepted beat, writes only at
	// write back, so the two never meet in one cycle.
	always_ff @(posedge clk) begin
		for (int j = 0; j < LANES; j++) begin
			if (op_acc) begin
				rd_a_s1[j] <= bank_q[j][row_a[j]];
				rd_b_s1[j] <= bank_q[j][row_b[j]];
				va_s1[j]   <= vld_q[j][row_a[j]];
				vb_s1[j]   <= vld_q[j][row_b[j]];
			end
			if (lane_we[j]) begin
				bank_q[j][row_w[j]] <= lane_wdata[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int j = 0; j < LANES; j++) begin
				if (lane_we[j]) begin
					vld_q[j][row_w[j]] <= 1'b1;
				end
			end
		end
	end

	// Operand words and the ALU.
	assign m_s1   = width_mask(wc_s1);
	assign a_w    = gather(rd_a_s1, va_s1, dst_s1[LANE_W-1:0]) & m_s1;
	assign b_w    = gather(rd_b_s1, vb_s1, src_s1[LANE_W-1:0]) & m_s1;
	assign bits_w = 7'd8 << wc_s1;
	assign rot_s  = imm_s1[5:0] & (bits_w[5:0] - 6'd1);
	assign shift_big = imm_s1 >= 64'(bits_w);

	always_comb begin
		unique case (state_q)
			ST_MUL_X1: begin
				mul_x = a_w[31:0];
				mul_y = imm_s1[63:32];
			end
			ST_MUL_X2: begin
				mul_x = a_w[63:32];
				mul_y = imm_s1[31:0];
			end
			default: begin
				mul_x = a_w[31:0];
				mul_y = imm_s1[31:0];
			end
		endcase
	end

	assign mul_p = mul_x * mul_y;

	always_comb begin
		unique case (kind_s1)
			KIND_MOV_IN:    r_w = inw_s1;
			KIND_MOV_IMM:   r_w = imm_s1;
			KIND_ROL:       r_w = (a_w << rot_s) | (a_w >> (bits_w - 7'(rot_s)));
			KIND_ROR:       r_w = (a_w >> rot_s) | (a_w << (bits_w - 7'(rot_s)));
			KIND_MUL:       r_w = mul_p;
			KIND_AND_IMM:   r_w = a_w & imm_s1;
			KIND_SHL:       r_w = shift_big ? '0 : (a_w << imm_s1[5:0]);
			KIND_SHR:       r_w = shift_big ? '0 : (a_w >> imm_s1[5:0]);
			KIND_OR_IMM:    r_w = a_w | imm_s1;
			KIND_XOR_IMM:   r_w = a_w ^ imm_s1;
			KIND_XOR_IN:    r_w = a_w ^ inw_s1;
			KIND_AND_IN:    r_w = a_w & inw_s1;
			KIND_ADD_IN:    r_w = a_w + inw_s1;
			KIND_SUB_IN:    r_w = a_w - inw_s1;
			KIND_MOV_STATE: r_w = b_w;
			KIND_XOR_STATE: r_w = a_w ^ b_w;
			KIND_SUB_STATE: r_w = a_w - b_w;
			KIND_ADD_STATE: r_w = a_w + b_w;
			default:        r_w = ~a_w;
		endcase
	end

	// Only a full 64-bit multiply needs the cross products.
	assign long_mul = (kind_s1 == KIND_MUL) && (wc_s1 == WC_64) && legal_s1 && !oor_s1;

	always_comb begin
		state_d    = state_q;
		commit_en  = 1'b0;
		commit_raw = r_w;
		unique case (state_q)
			ST_IDLE: begin
				if (op.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (long_mul) begin
					state_d = ST_MUL_X1;
				end else if (out_free) begin
					commit_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_MUL_X1: state_d = ST_MUL_X2;
			ST_MUL_X2: state_d = ST_WB;
			ST_WB: begin
				commit_raw = res_q;
				if (out_free) begin
					commit_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign commit_write = commit_en && legal_s1 && !oor_s1;
	assign commit_val   = (legal_s1 && !oor_s1) ? (commit_raw & m_s1) : '0;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			logic [LANE_W-1:0] bi;
			bi            = LANE_W'(j) - dst_s1[LANE_W-1:0];
			lane_we[j]    = commit_write && ({1'b0, bi} < width_bytes(wc_s1));
			lane_wdata[j] = commit_val[{bi, 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Product accumulator for the 64-bit multiply.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && long_mul) begin
			res_q <= mul_p;
		end else if (state_q == ST_MUL_X1 || state_q == ST_MUL_X2) begin
			res_q <= res_q + {mul_p[31:0], 32'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit_en) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			res_value_q <= commit_val;
			res_oor_q   <= legal_s1 && oor_s1;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.written_value = res_value_q;
	assign res.out_of_range  = res_oor_q;

	`HPOX_ASSERT(a_accept_reads, op_acc |=> state_q == ST_EXEC, "accepted beat did not start a read")
	`HPOX_ASSERT_NEVER(a_idle_no_write, (state_q == ST_IDLE) && (lane_we != '0), "lane write while idle")
	`HPOX_ASSERT(a_commit_result, commit_en |=> (state_q == ST_IDLE) && res.valid, "commit lost its result")
	`HPOX_ASSERT(a_oor_zero, (res.valid && res.out_of_range) |-> (res.written_value == '0), "flagged beat carries data")

endmodule
